// File: src/imh_pkg.sv
// Shared types, codes and signature tables for the image header sniffer.
`default_nettype none

package imh_pkg;

  // Default width of the byte position counters
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Reported format codes
  localparam logic [2:0] FMT_NONE = 3'd0;
  localparam logic [2:0] FMT_PNG  = 3'd1;
  localparam logic [2:0] FMT_JPEG = 3'd2;
  localparam logic [2:0] FMT_GIF  = 3'd3;
  localparam logic [2:0] FMT_BMP  = 3'd4;

  // Bit of each format in the signature match vector
  localparam int unsigned SIG_PNG  = 0;
  localparam int unsigned SIG_JPEG = 1;
  localparam int unsigned SIG_GIF  = 2;
  localparam int unsigned SIG_BMP  = 3;

  // JPEG marker codes
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_SOF_LO = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI = 8'hC3;

  // One result beat
  typedef struct packed {
    logic               found;
    logic [2:0]         image_format;
    logic signed [31:0] width;
    logic signed [31:0] height;
    logic [15:0]        sample_bits;
    logic [2:0]         colour_kind;
  } res_t;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] jpeg_sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd1: b = 8'hD8;
      default: b = 8'hFF;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] gif_sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h47;
      2'd1: b = 8'h49;
      2'd2: b = 8'h46;
      default: b = 8'h38;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] bmp_sig_byte(input logic idx);
    return idx ? 8'h4D : 8'h42;
  endfunction

  // PNG colour type byte to reported colour code
  function automatic logic [2:0] png_colour(input logic [7:0] raw);
    logic [2:0] c;
    case (raw)
      8'd0: c = 3'd1;
      8'd2: c = 3'd2;
      8'd3: c = 3'd3;
      8'd4: c = 3'd4;
      8'd6: c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: src/imh_byte_if.sv
// Valid/ready channel carrying one file byte per beat.
`default_nettype none

interface imh_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: src/imh_result_if.sv
// Valid/ready channel carrying one header result per beat.
`default_nettype none

interface imh_result_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [2:0]         image_format;
  logic signed [31:0] width;
  logic signed [31:0] height;
  logic [15:0]        sample_bits;
  logic [2:0]         colour_kind;

  modport source(output valid, output found, output image_format, output width,
                 output height, output sample_bits, output colour_kind, input ready);
  modport sink(input valid, input found, input image_format, input width,
               input height, input sample_bits, input colour_kind, output ready);
endinterface

`default_nettype wire

// File: src/image_header_metadata_parser.sv
// A result is registered into the output register after its last byte is accepted, or into the skid entry
// while that register still holds an earlier result. Throughput: one byte per cycle while input ready is high;
// every byte is handled in one pass of the state logic. Input ready drops only while both the output register
// and its skid entry hold results. Reset (synchronous, rst high) clears the header state and empties the result
// buffer; the state also returns to its reset values after each last byte.
`default_nettype none

module image_header_metadata_parser #(
  parameter int unsigned POSITION_BITS = imh_pkg::POSITION_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  imh_byte_if.sink     bytes,
  imh_result_if.source result
);
  import imh_pkg::*;

  logic acc;
  logic space;
  logic res_fire;
  res_t res;

  assign bytes.ready = space;
  assign acc         = bytes.valid && space;

  // Header tracking, one byte per beat
  imh_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .data_byte(bytes.data_byte),
    .last_byte(bytes.last_byte),
    .res_fire (res_fire),
    .res      (res)
  );

  // Result register and skid
  imh_outbuf u_outbuf (
    .clk   (clk),
    .rst   (rst),
    .push  (res_fire),
    .din   (res),
    .space (space),
    .result(result)
  );

endmodule

`default_nettype wire

// File: src/imh_core.sv
// Per-byte header state: signature match, fixed-offset capture and JPEG marker walk.
`default_nettype none

module imh_core #(
  parameter int unsigned POSITION_BITS = imh_pkg::POSITION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         acc,
  input  wire logic [7:0]   data_byte,
  input  wire logic         last_byte,
  output logic              res_fire,
  output imh_pkg::res_t     res
);
  import imh_pkg::*;

  localparam int unsigned P = POSITION_BITS;
  localparam int unsigned W = POSITION_BITS + 2;
  localparam logic [P-1:0] POS_MAX = {P{1'b1}};

  logic [P-1:0]  pos, pos_next;
  logic [3:0]    sig, sig_next;
  logic [7:0]    rb0, rb1, rb2;
  logic [31:0]   width_v, width_next;
  logic [31:0]   height_v, height_next;
  logic [15:0]   depth_v, depth_next;
  logic [2:0]    colour, colour_next;
  logic [P-1:0]  nmp, nmp_next;
  logic          stopped, stopped_next;
  logic [P-1:0]  fhs, fhs_next;
  logic          fha, fha_next;

  logic [P-1:0]  fh_off;
  logic [W-1:0]  walk_sum;
  logic          walk_hit;
  logic [1:0]    lane;
  logic [2:0]    fmt;

  // Next state for one accepted byte
  always_comb begin
    sig_next     = sig;
    width_next   = width_v;
    height_next  = height_v;
    depth_next   = depth_v;
    colour_next  = colour;
    nmp_next     = nmp;
    stopped_next = stopped;
    fhs_next     = fhs;
    fha_next     = fha;
    fh_off       = pos - fhs;
    walk_sum     = {2'b00, nmp};
    walk_hit     = !stopped && (({2'b00, nmp} + W'(3)) == {2'b00, pos});
    lane         = 2'd0;

    // signature checks on the leading bytes
    if (pos < P'(8) && data_byte != png_sig_byte(pos[2:0])) sig_next[SIG_PNG] = 1'b0;
    if (pos < P'(3) && data_byte != jpeg_sig_byte(pos[1:0])) sig_next[SIG_JPEG] = 1'b0;
    if (pos < P'(4) && data_byte != gif_sig_byte(pos[1:0])) sig_next[SIG_GIF] = 1'b0;
    if (pos < P'(2) && data_byte != bmp_sig_byte(pos[0])) sig_next[SIG_BMP] = 1'b0;

    if (pos != POS_MAX) begin
      if (sig_next[SIG_PNG]) begin
        // big-endian fields
        lane = 2'd3 - pos[1:0];
        if (pos == P'(7)) begin
          colour_next = 3'd1;
        end else if (pos >= P'(16) && pos <= P'(19)) begin
          width_next[8*lane +: 8] = data_byte;
        end else if (pos >= P'(20) && pos <= P'(23)) begin
          height_next[8*lane +: 8] = data_byte;
        end else if (pos == P'(24)) begin
          depth_next = {8'h00, data_byte};
        end else if (pos == P'(25)) begin
          colour_next = png_colour(data_byte);
        end
      end else if (sig_next[SIG_JPEG]) begin
        // fill the active frame header
        if (fha && pos >= fhs) begin
          if (fh_off == P'(4)) begin
            depth_next = {8'h00, data_byte};
          end else if (fh_off == P'(5)) begin
            height_next[15:8] = data_byte;
          end else if (fh_off == P'(6)) begin
            height_next[7:0] = data_byte;
          end else if (fh_off == P'(7)) begin
            width_next[15:8] = data_byte;
          end else if (fh_off == P'(8)) begin
            width_next[7:0] = data_byte;
            fha_next        = 1'b0;
          end
        end
        // marker walk: byte p is rb2, marker rb1, length {rb0, data_byte}
        if (walk_hit) begin
          if (rb2 != MARK_PREFIX) begin
            walk_sum = {2'b00, nmp} + W'(1);
          end else if (rb1 == MARK_EOI || rb1 == MARK_SOS) begin
            stopped_next = 1'b1;
          end else begin
            if (rb1 >= MARK_SOF_LO && rb1 <= MARK_SOF_HI) begin
              fhs_next    = nmp;
              fha_next    = 1'b1;
              width_next  = '0;
              height_next = '0;
              depth_next  = '0;
            end
            walk_sum = {2'b00, nmp} + W'({rb0, data_byte}) + W'(2);
          end
          nmp_next = (walk_sum > {2'b00, POS_MAX}) ? POS_MAX : walk_sum[P-1:0];
        end
      end else if (sig_next[SIG_GIF]) begin
        if (pos == P'(3)) begin
          depth_next = 16'd1;
        end else if (pos == P'(6)) begin
          width_next[7:0] = data_byte;
        end else if (pos == P'(7)) begin
          width_next[15:8] = data_byte;
        end else if (pos == P'(8)) begin
          height_next[7:0] = data_byte;
        end else if (pos == P'(9)) begin
          height_next[15:8] = data_byte;
        end else if (pos == P'(10)) begin
          depth_next = {13'd0, data_byte[6:4]} + 16'd1;
        end
      end else if (sig_next[SIG_BMP]) begin
        // little-endian fields starting at 18 and 22
        lane = pos[1:0] + 2'd2;
        if (pos >= P'(18) && pos <= P'(21)) begin
          width_next[8*lane +: 8] = data_byte;
        end else if (pos >= P'(22) && pos <= P'(25)) begin
          height_next[8*lane +: 8] = data_byte;
        end else if (pos == P'(28)) begin
          depth_next[7:0] = data_byte;
        end else if (pos == P'(29)) begin
          depth_next[15:8] = data_byte;
        end
      end
    end

    pos_next = (pos != POS_MAX) ? pos + P'(1) : pos;
  end

  // Result for a last byte
  always_comb begin
    if (sig_next[SIG_PNG] && pos >= P'(7)) begin
      fmt = FMT_PNG;
    end else if (sig_next[SIG_JPEG] && pos >= P'(2)) begin
      fmt = FMT_JPEG;
    end else if (sig_next[SIG_GIF] && pos >= P'(3)) begin
      fmt = FMT_GIF;
    end else if (sig_next[SIG_BMP] && pos >= P'(1)) begin
      fmt = FMT_BMP;
    end else begin
      fmt = FMT_NONE;
    end
    res_fire = acc && last_byte;
    if (fmt == FMT_NONE) begin
      res = '0;
    end else begin
      res.found        = 1'b1;
      res.image_format = fmt;
      res.width        = width_next;
      res.height       = height_next;
      res.sample_bits  = depth_next;
      res.colour_kind  = (fmt == FMT_PNG) ? colour_next : 3'd0;
    end
  end

  // State registers; a last byte returns everything to the reset values
  always_ff @(posedge clk) begin
    if (rst || (acc && last_byte)) begin
      pos      <= '0;
      sig      <= 4'hF;
      rb0      <= '0;
      rb1      <= '0;
      rb2      <= '0;
      width_v  <= '0;
      height_v <= '0;
      depth_v  <= '0;
      colour   <= '0;
      nmp      <= P'(2);
      stopped  <= 1'b0;
      fhs      <= '0;
      fha      <= 1'b0;
    end else if (acc) begin
      pos      <= pos_next;
      sig      <= sig_next;
      rb0      <= data_byte;
      rb1      <= rb0;
      rb2      <= rb1;
      width_v  <= width_next;
      height_v <= height_next;
      depth_v  <= depth_next;
      colour   <= colour_next;
      nmp      <= nmp_next;
      stopped  <= stopped_next;
      fhs      <= fhs_next;
      fha      <= fha_next;
    end
  end

`ifndef SYNTH
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (acc && last_byte) |=> (pos == '0 && sig == 4'hF && !fha && !stopped))
    else $error("state not cleared after last byte");
  a_walk_floor: assert property (@(posedge clk) disable iff (rst)
    nmp >= P'(2))
    else $error("marker walk position below start offset");
  a_frame_is_jpeg: assert property (@(posedge clk) disable iff (rst)
    fha |-> sig[SIG_JPEG])
    else $error("frame header active without JPEG signature");
`endif

endmodule

`default_nettype wire

// File: src/imh_outbuf.sv
// Result register with one skid entry so bytes keep flowing while a result waits.
`default_nettype none

module imh_outbuf (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire imh_pkg::res_t din,
  output logic               space,
  imh_result_if.source       result
);
  import imh_pkg::*;

  logic out_valid, skid_valid;
  res_t out_data, skid_data;
  logic take;

  assign take  = out_valid && result.ready;
  assign space = !skid_valid;

  // Output slot refills from the skid entry first, keeping beat order
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= push;
        skid_data  <= din;
      end else begin
        out_valid <= push;
        out_data  <= din;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid_data  <= din;
    end
  end

  assign result.valid        = out_valid;
  assign result.found        = out_data.found;
  assign result.image_format = out_data.image_format;
  assign result.width        = out_data.width;
  assign result.height       = out_data.height;
  assign result.sample_bits  = out_data.sample_bits;
  assign result.colour_kind  = out_data.colour_kind;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held with empty output slot");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into full buffer");
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !take) |=> skid_valid)
    else $error("skid entry dropped while output stalled");
`endif

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the image header sniffer: random and directed image files.
`timescale 1ns / 100ps

module testbench;
  import imh_pkg::*;

  // Width of the position counters in the device under test
  localparam int POS_BITS    = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int MIN_BYTES   = 650;
  localparam int MIN_FILES   = 40;
  localparam int DRAIN_LIMIT = 2000;

  // Magic numbers, first byte in the top lane
  localparam logic [63:0] PNG_MAGIC  = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [23:0] JPEG_MAGIC = 24'hFF_D8FF;
  localparam logic [31:0] GIF_MAGIC  = 32'h4749_4638;
  localparam logic [15:0] BMP_MAGIC  = 16'h424D;
  localparam int PNG_LEN  = 8;
  localparam int JPEG_LEN = 3;
  localparam int GIF_LEN  = 4;
  localparam int BMP_LEN  = 2;

  // Raw PNG colour type byte values
  localparam logic [7:0] PNG_RAW_GREY       = 8'd0;
  localparam logic [7:0] PNG_RAW_RGB        = 8'd2;
  localparam logic [7:0] PNG_RAW_INDEXED    = 8'd3;
  localparam logic [7:0] PNG_RAW_GREY_ALPHA = 8'd4;
  localparam logic [7:0] PNG_RAW_RGBA       = 8'd6;

  // Other JPEG markers used in random files
  localparam logic [7:0] MARK_SOI  = 8'hD8;
  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_DQT  = 8'hDB;
  localparam logic [7:0] MARK_DHT  = 8'hC4;
  localparam logic [7:0] MARK_COM  = 8'hFE;

  typedef enum logic [2:0] {
    COLOUR_UNKNOWN, COLOUR_GREY, COLOUR_RGB, COLOUR_INDEXED, COLOUR_GREY_ALPHA, COLOUR_RGBA
  } colour_e;

  typedef logic [7:0] file_t [$];

  // Header predictor and store of expected result beats
  class header_scoreboard;
    longint unsigned pos_limit;
    longint unsigned byte_pos;
    longint unsigned walk_pos;
    longint unsigned frame_pos;
    logic [3:0]      sig_alive;
    logic [7:0]      prev_bytes [3];
    logic [31:0]     width_acc;
    logic [31:0]     height_acc;
    logic [15:0]     depth_acc;
    colour_e         colour_acc;
    bit              walk_done;
    bit              frame_open;
    res_t            expected_headers [$];
    int              mismatch_count;
    int              byte_count;
    int              file_count;
    int              result_count;
    int              format_count [5];

    function new(int pos_bits);
      pos_limit      = (64'd1 << pos_bits) - 64'd1;
      mismatch_count = 0;
      byte_count     = 0;
      file_count     = 0;
      result_count   = 0;
      format_count   = '{default: 0};
      restart();
    endfunction

    function void restart();
      byte_pos   = 0;
      sig_alive  = 4'hF;
      prev_bytes = '{default: 8'h00};
      width_acc  = '0;
      height_acc = '0;
      depth_acc  = '0;
      colour_acc = COLOUR_UNKNOWN;
      walk_pos   = 2;
      walk_done  = 1'b0;
      frame_pos  = 0;
      frame_open = 1'b0;
    endfunction

    // Advance the predictor by one accepted byte beat
    function void note_byte(logic [7:0] b, logic last);
      longint unsigned i;
      longint unsigned d;
      logic [2:0]      fmt;
      res_t            exp;
      i = byte_pos;
      byte_count++;

      // Drop every format whose signature this byte breaks
      if (i < PNG_LEN && PNG_MAGIC[8*(PNG_LEN-1-int'(i)) +: 8] != b) sig_alive[SIG_PNG] = 1'b0;
      if (i < JPEG_LEN && JPEG_MAGIC[8*(JPEG_LEN-1-int'(i)) +: 8] != b)
        sig_alive[SIG_JPEG] = 1'b0;
      if (i < GIF_LEN && GIF_MAGIC[8*(GIF_LEN-1-int'(i)) +: 8] != b) sig_alive[SIG_GIF] = 1'b0;
      if (i < BMP_LEN && BMP_MAGIC[8*(BMP_LEN-1-int'(i)) +: 8] != b) sig_alive[SIG_BMP] = 1'b0;

      // Field capture; nothing is taken once the position has saturated
      if (i < pos_limit) begin
        if (sig_alive[SIG_PNG]) begin
          if (i == 7) colour_acc = COLOUR_GREY;
          else if (i >= 16 && i <= 19) width_acc[8*(19-int'(i)) +: 8] = b;
          else if (i >= 20 && i <= 23) height_acc[8*(23-int'(i)) +: 8] = b;
          else if (i == 24) depth_acc = {8'h00, b};
          else if (i == 25) begin
            case (b)
              PNG_RAW_GREY:       colour_acc = COLOUR_GREY;
              PNG_RAW_RGB:        colour_acc = COLOUR_RGB;
              PNG_RAW_INDEXED:    colour_acc = COLOUR_INDEXED;
              PNG_RAW_GREY_ALPHA: colour_acc = COLOUR_GREY_ALPHA;
              PNG_RAW_RGBA:       colour_acc = COLOUR_RGBA;
              default:            colour_acc = COLOUR_UNKNOWN;
            endcase
          end
        end else if (sig_alive[SIG_JPEG]) begin
          // Frame header bytes fill in as they pass
          if (frame_open && i >= frame_pos) begin
            d = i - frame_pos;
            case (d)
              4: depth_acc = {8'h00, b};
              5: height_acc[15:8] = b;
              6: height_acc[7:0] = b;
              7: width_acc[15:8] = b;
              8: begin
                width_acc[7:0] = b;
                frame_open = 1'b0;
              end
              default: ;
            endcase
          end
          // Marker walk: decide on offset walk_pos once three more bytes have come
          if (!walk_done && walk_pos + 3 == i) begin
            if (prev_bytes[2] != MARK_PREFIX) begin
              walk_pos = walk_pos + 1;
            end else if (prev_bytes[1] == MARK_EOI || prev_bytes[1] == MARK_SOS) begin
              walk_done = 1'b1;
            end else begin
              if (prev_bytes[1] >= MARK_SOF_LO && prev_bytes[1] <= MARK_SOF_HI) begin
                frame_pos  = walk_pos;
                frame_open = 1'b1;
                width_acc  = '0;
                height_acc = '0;
                depth_acc  = '0;
              end
              walk_pos = walk_pos + longint'({prev_bytes[0], b}) + 2;
            end
            if (walk_pos > pos_limit) walk_pos = pos_limit;
          end
        end else if (sig_alive[SIG_GIF]) begin
          if (i == 3) depth_acc = 16'd1;
          else if (i == 6 || i == 7) width_acc[8*(int'(i)-6) +: 8] = b;
          else if (i == 8 || i == 9) height_acc[8*(int'(i)-8) +: 8] = b;
          else if (i == 10) depth_acc = {13'd0, b[6:4]} + 16'd1;
        end else if (sig_alive[SIG_BMP]) begin
          if (i >= 18 && i <= 21) width_acc[8*(int'(i)-18) +: 8] = b;
          else if (i >= 22 && i <= 25) height_acc[8*(int'(i)-22) +: 8] = b;
          else if (i == 28) depth_acc[7:0] = b;
          else if (i == 29) depth_acc[15:8] = b;
        end
      end

      prev_bytes[2] = prev_bytes[1];
      prev_bytes[1] = prev_bytes[0];
      prev_bytes[0] = b;

      if (!last) begin
        if (byte_pos < pos_limit) byte_pos++;
        return;
      end

      // Last byte: a format counts only if the file covers its whole signature
      if (sig_alive[SIG_PNG] && i + 1 >= PNG_LEN) fmt = FMT_PNG;
      else if (sig_alive[SIG_JPEG] && i + 1 >= JPEG_LEN) fmt = FMT_JPEG;
      else if (sig_alive[SIG_GIF] && i + 1 >= GIF_LEN) fmt = FMT_GIF;
      else if (sig_alive[SIG_BMP] && i + 1 >= BMP_LEN) fmt = FMT_BMP;
      else fmt = FMT_NONE;

      exp = '0;
      if (fmt != FMT_NONE) begin
        exp.found        = 1'b1;
        exp.image_format = fmt;
        exp.width        = width_acc;
        exp.height       = height_acc;
        exp.sample_bits  = depth_acc;
        if (fmt == FMT_PNG) exp.colour_kind = colour_acc;
      end
      expected_headers.push_back(exp);
      file_count++;
      format_count[fmt]++;
      restart();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH result %0d: %s", $time, result_count, what);
      mismatch_count++;
    endtask

    // Compare one accepted result beat with the oldest expectation
    task check_result(res_t got);
      res_t exp;
      result_count++;
      if (expected_headers.size() == 0) begin
        report_mismatch("result beat with no file pending");
      end else begin
        exp = expected_headers.pop_front();
        if (got.found !== exp.found)
          report_mismatch($sformatf("found %0d, expected %0d", got.found, exp.found));
        if (got.image_format !== exp.image_format)
          report_mismatch($sformatf("image_format %0d, expected %0d",
                                    got.image_format, exp.image_format));
        if (got.width !== exp.width)
          report_mismatch($sformatf("width %0d, expected %0d", got.width, exp.width));
        if (got.height !== exp.height)
          report_mismatch($sformatf("height %0d, expected %0d", got.height, exp.height));
        if (got.sample_bits !== exp.sample_bits)
          report_mismatch($sformatf("sample_bits %0d, expected %0d",
                                    got.sample_bits, exp.sample_bits));
        if (got.colour_kind !== exp.colour_kind)
          report_mismatch($sformatf("colour_kind %0d, expected %0d",
                                    got.colour_kind, exp.colour_kind));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic sink_idle_on;
  logic hold_req;
  logic hold_done;
  bit   src_idle_on;

  imh_byte_if   byte_ch();
  imh_result_if res_ch();

  header_scoreboard board;

  image_header_metadata_parser #(
    .POSITION_BITS(POS_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .bytes(byte_ch),
    .result(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("Mismatches found");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    res_ch.ready <= 1'b0;
    hold_done    <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done    <= 1'b1;
        res_ch.ready <= 1'b1;
      end else if (sink_idle_on && $urandom_range(99) < 10) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.found        = res_ch.found;
      got.image_format = res_ch.image_format;
      got.width        = res_ch.width;
      got.height       = res_ch.height;
      got.sample_bits  = res_ch.sample_bits;
      got.colour_kind  = res_ch.colour_kind;
      board.check_result(got);
    end
  end

  // Biased byte: extremes come up often
  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  // Mostly well-formed headers with random content, some noise and damage
  function automatic file_t random_file();
    file_t      f;
    int         kind;
    int         k;
    int         n;
    int         segs;
    logic [7:0] mark;
    logic [15:0] seg_len;
    kind = $urandom_range(99);
    if (kind < 20) begin
      for (k = 0; k < PNG_LEN; k++) f.push_back(PNG_MAGIC[8*(PNG_LEN-1-k) +: 8]);
      repeat (16 - PNG_LEN + 8) f.push_back(rand_byte());
      case ($urandom_range(3))
        0:       f.push_back(8'd8);
        1:       f.push_back(8'd16);
        2:       f.push_back(8'd1);
        default: f.push_back(rand_byte());
      endcase
      f.push_back(($urandom_range(9) == 0) ? rand_byte() : 8'($urandom_range(7)));
      repeat ($urandom_range(8, 4)) f.push_back(rand_byte());
    end else if (kind < 55) begin
      f.push_back(MARK_PREFIX);
      f.push_back(MARK_SOI);
      segs = $urandom_range(4, 1);
      for (k = 0; k < segs; k++) begin
        if (k > 0 && $urandom_range(99) < 20)
          repeat ($urandom_range(2, 1)) f.push_back(rand_byte());
        case ($urandom_range(8))
          0, 1, 2, 3: mark = MARK_SOF_LO + 8'($urandom_range(3));
          4:          mark = MARK_APP0;
          5:          mark = MARK_DQT;
          6:          mark = MARK_DHT;
          7:          mark = MARK_COM;
          default:    mark = 8'($urandom_range(255));
        endcase
        f.push_back(MARK_PREFIX);
        f.push_back(mark);
        if (mark >= MARK_SOF_LO && mark <= MARK_SOF_HI) begin
          n = $urandom_range(3, 1);
          seg_len = 16'(8 + 3 * n);
          f.push_back(seg_len[15:8]);
          f.push_back(seg_len[7:0]);
          f.push_back($urandom_range(1) ? 8'd8 : rand_byte());
          repeat (4) f.push_back(rand_byte());
          f.push_back(8'(n));
          repeat (3 * n) f.push_back(rand_byte());
        end else begin
          seg_len = ($urandom_range(99) < 6) ? 16'($urandom_range(1)) : 16'($urandom_range(10, 2));
          f.push_back(seg_len[15:8]);
          f.push_back(seg_len[7:0]);
          repeat ((seg_len >= 2) ? seg_len - 2 : 0) f.push_back(rand_byte());
        end
      end
      case ($urandom_range(3))
        0, 1: begin
          f.push_back(MARK_PREFIX);
          f.push_back(MARK_EOI);
        end
        2: begin
          f.push_back(MARK_PREFIX);
          f.push_back(MARK_SOS);
          repeat ($urandom_range(3, 1)) f.push_back(rand_byte());
        end
        default: ;
      endcase
    end else if (kind < 70) begin
      for (k = 0; k < GIF_LEN; k++) f.push_back(GIF_MAGIC[8*(GIF_LEN-1-k) +: 8]);
      f.push_back($urandom_range(1) ? 8'h39 : 8'h37);
      f.push_back(8'h61);
      repeat ($urandom_range(9, 5)) f.push_back(rand_byte());
    end else if (kind < 85) begin
      f.push_back(BMP_MAGIC[15:8]);
      f.push_back(BMP_MAGIC[7:0]);
      repeat ($urandom_range(32, 28)) f.push_back(rand_byte());
    end else begin
      repeat ($urandom_range(20, 1)) f.push_back(rand_byte());
    end

    // Truncate the file or corrupt its signature area now and then
    kind = $urandom_range(99);
    if (kind < 12) begin
      n = $urandom_range(f.size(), 1);
      while (f.size() > n) void'(f.pop_back());
    end else if (kind < 18) begin
      n = (f.size() < PNG_LEN) ? f.size() : PNG_LEN;
      f[$urandom_range(n - 1)] = 8'($urandom_range(255));
    end
    return f;
  endfunction

  // Offer one byte beat and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (src_idle_on && $urandom_range(99) < 10) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    board.note_byte(b, last);
  endtask

  task automatic send_file(input file_t f);
    int k;
    for (k = 0; k < f.size(); k++) send_byte(f[k], k == f.size() - 1);
  endtask

  // Stimulus
  initial begin
    file_t       f;
    int          drain_cycles;
    board = new(POS_BITS);
    rst               <= 1'b1;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    sink_idle_on      <= 1'b1;
    hold_req          <= 1'b0;
    src_idle_on = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: short signatures, bare signatures, no format, immediate end of image
    f = '{8'h89};
    send_file(f);
    f = '{8'h00};
    send_file(f);
    f = '{8'h42, 8'h4D};
    send_file(f);
    f = '{8'h47, 8'h49, 8'h46, 8'h38};
    send_file(f);
    f = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    send_file(f);
    f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX};
    send_file(f);
    f = '{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_EOI, 8'h00};
    send_file(f);

    // Random files with idling on both sides
    while (board.byte_count < 250) send_file(random_file());

    // Receiver holds off while small files keep coming, so the input stalls
    hold_req <= 1'b1;
    while (!hold_done) begin
      f.delete();
      if ($urandom_range(1)) begin
        f.push_back(BMP_MAGIC[15:8]);
        f.push_back(BMP_MAGIC[7:0]);
      end else begin
        f.push_back(rand_byte());
      end
      send_file(f);
    end

    // Sender pauses until every result is out
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_headers.size() != 0) @(posedge clk);

    // Stretch with no idling at all
    src_idle_on = 1'b0;
    sink_idle_on <= 1'b0;
    while (board.byte_count < 420) send_file(random_file());
    src_idle_on = 1'b1;
    sink_idle_on <= 1'b1;

    while (board.byte_count < MIN_BYTES || board.file_count < MIN_FILES)
      send_file(random_file());

    // Drain
    byte_ch.valid <= 1'b0;
    drain_cycles = 0;
    while (board.expected_headers.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    if (board.expected_headers.size() != 0)
      board.report_mismatch($sformatf("%0d expected results never arrived",
                                      board.expected_headers.size()));

    $display("Run covered %0d files in %0d bytes: PNG %0d, JPEG %0d, GIF %0d, BMP %0d, none %0d.",
             board.file_count, board.byte_count, board.format_count[FMT_PNG],
             board.format_count[FMT_JPEG], board.format_count[FMT_GIF],
             board.format_count[FMT_BMP], board.format_count[FMT_NONE]);
    $display("Also covered an output hold-off, a drain pause and an idle-free stretch.");
    if (board.mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
